// ===== rtl/tdl_pkg.sv =====
// tdl_pkg: shared types, codes and tables for the table-driven lexer.
// Character columns, token classes, scan states, keyword table, classifier.
// No dependencies.
package tdl_pkg;

    // character columns
    typedef logic [4:0] col_t;
    localparam col_t COL_LETTER  = 5'd0;
    localparam col_t COL_DIGIT   = 5'd1;
    localparam col_t COL_COLON   = 5'd2;
    localparam col_t COL_EQUAL   = 5'd3;
    localparam col_t COL_PLUS    = 5'd4;
    localparam col_t COL_MINUS   = 5'd5;
    localparam col_t COL_LESS    = 5'd6;
    localparam col_t COL_GREATER = 5'd7;
    localparam col_t COL_SEMI    = 5'd8;
    localparam col_t COL_COMMA   = 5'd9;
    localparam col_t COL_LPAREN  = 5'd10;
    localparam col_t COL_RPAREN  = 5'd11;
    localparam col_t COL_LBRACE  = 5'd12;
    localparam col_t COL_RBRACE  = 5'd13;
    localparam col_t COL_QUOTE   = 5'd14;
    localparam col_t COL_TAB     = 5'd15;
    localparam col_t COL_LF      = 5'd16;
    localparam col_t COL_SPACE   = 5'd17;
    localparam col_t COL_PERIOD  = 5'd18;
    localparam col_t COL_STAR    = 5'd19;
    localparam col_t COL_SLASH   = 5'd20;
    localparam col_t COL_END     = 5'd21;
    localparam col_t COL_FOREIGN = 5'd22;

    // token classes
    typedef logic [5:0] class_t;
    localparam class_t CLS_BAD_NUMBER  = 6'd0;
    localparam class_t CLS_INTEGER     = 6'd1;
    localparam class_t CLS_IDENT       = 6'd2;
    localparam class_t CLS_BECOMES     = 6'd3;
    localparam class_t CLS_PLUS        = 6'd4;
    localparam class_t CLS_MINUS       = 6'd5;
    localparam class_t CLS_EQUAL       = 6'd6;
    localparam class_t CLS_LESS        = 6'd7;
    localparam class_t CLS_NOT_EQUAL   = 6'd8;
    localparam class_t CLS_LESS_EQ     = 6'd9;
    localparam class_t CLS_GREATER     = 6'd10;
    localparam class_t CLS_GREATER_EQ  = 6'd11;
    localparam class_t CLS_SEMI        = 6'd12;
    localparam class_t CLS_COMMA       = 6'd13;
    localparam class_t CLS_RPAREN      = 6'd14;
    localparam class_t CLS_LPAREN      = 6'd15;
    localparam class_t CLS_BAD_ASSIGN  = 6'd16;
    localparam class_t CLS_PERIOD      = 6'd17;
    localparam class_t CLS_STAR        = 6'd18;
    localparam class_t CLS_SLASH       = 6'd19;
    localparam class_t CLS_FOREIGN     = 6'd20;
    localparam class_t CLS_BAD_COMMENT = 6'd21;
    localparam class_t CLS_KEYWORD0    = 6'd22;
    localparam class_t CLS_END         = 6'd33;

    typedef enum logic [4:0] {
        ST_START   = 5'd0,
        ST_NUMBER  = 5'd1,
        ST_IDENT   = 5'd4,
        ST_COLON   = 5'd6,
        ST_LESS    = 5'd11,
        ST_GREATER = 5'd15,
        ST_COMMENT = 5'd22
    } scan_state_t;

    // one classified source byte
    typedef struct packed {
        col_t       col;
        logic [7:0] ch;
    } item_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // keywords, right-justified strings; char i sits at [(len-1-i)*8 +: 8]
    localparam int KW_COUNT = 11;
    localparam int KW_MAX   = 9;
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
        "CONST", "VAR", "PROCEDURE", "CALL", "BEGIN", "END",
        "IF", "THEN", "WHILE", "DO", "ODD"
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 3, 9, 4, 5, 3, 2, 4, 5, 2, 3};

    function automatic col_t classify(input logic [7:0] c, input logic eoi);
        col_t col;
        begin
            col = COL_FOREIGN;
            if (eoi)
            begin
                col = COL_END;
            end
            else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            begin
                col = COL_LETTER;
            end
            else if (c >= "0" && c <= "9")
            begin
                col = COL_DIGIT;
            end
            else
            begin
                case (c)
                    ":":     col = COL_COLON;
                    "=":     col = COL_EQUAL;
                    "+":     col = COL_PLUS;
                    "-":     col = COL_MINUS;
                    "<":     col = COL_LESS;
                    ">":     col = COL_GREATER;
                    ";":     col = COL_SEMI;
                    ",":     col = COL_COMMA;
                    "(":     col = COL_LPAREN;
                    ")":     col = COL_RPAREN;
                    "{":     col = COL_LBRACE;
                    "}":     col = COL_RBRACE;
                    8'h27:   col = COL_QUOTE;
                    8'h09:   col = COL_TAB;
                    8'h0A:   col = COL_LF;
                    8'h20:   col = COL_SPACE;
                    ".":     col = COL_PERIOD;
                    "*":     col = COL_STAR;
                    "/":     col = COL_SLASH;
                    default: col = COL_FOREIGN;
                endcase
            end
            return col;
        end
    endfunction

endpackage

// ===== rtl/table_driven_lexer.sv =====
// table_driven_lexer: top level over tdl_front, tdl_queue and tdl_back (tdl_pkg).
// A source byte passes the input stage, a queue entry and the output register
// before its first token shows. Throughput: one source byte per cycle while the
// queue has room; one token per cycle leaves unless stalled, so a byte yielding
// two tokens holds the next token-making byte until the spill register empties.
// Reset: scan state start, lexeme count 0, line count 1, queue and output empty.
module table_driven_lexer
    import tdl_pkg::*;
#(
    parameter int LEXEME_LIMIT  = 100,
    parameter int KEYWORD_CHARS = 9,
    parameter int LINE_BITS     = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // source byte channel
    input  logic                                src_valid,
    output logic                                src_stall,
    input  logic [7:0]                          character,
    input  logic                                end_of_input,
    // token channel
    output logic                                tok_valid,
    input  logic                                tok_stall,
    output logic [5:0]                          token_class,
    output logic [$clog2(LEXEME_LIMIT + 1)-1:0] lexeme_length,
    output logic [LINE_BITS-1:0]                line_number,
    output logic                                last_of_run
);

    localparam int LEN_W = $clog2(LEXEME_LIMIT + 1);

    // front -> queue
    logic  front_valid;
    item_t front_item;
    logic  front_ready;

    // queue -> engine
    logic  head_valid;
    item_t head_item;
    logic  head_pop;

    // Front: registers the byte and its column. It keeps taking transfers
    // as long as the queue has room, whatever the token side is doing.
    tdl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .character    (character),
        .end_of_input (end_of_input),
        .item_valid   (front_valid),
        .item         (front_item),
        .item_ready   (front_ready)
    );

    // Short queue decoupling classification from the scan engine.
    tdl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_item  (front_item),
        .push_ready (front_ready),
        .pop_valid  (head_valid),
        .pop_item   (head_item),
        .pop        (head_pop)
    );

    // Engine: one table step per byte, plus the restart from the start state
    // in the same cycle when the lookahead is not consumed. The output
    // register and a one-token spill register carry the results.
    // The keyword window is not cleared; only entries already written are compared.
    tdl_back #(
        .LEXEME_LIMIT  (LEXEME_LIMIT),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LINE_BITS     (LINE_BITS),
        .LEN_W         (LEN_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (head_valid),
        .item          (head_item),
        .item_pop      (head_pop),
        .tok_valid     (tok_valid),
        .tok_stall     (tok_stall),
        .token_class   (token_class),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_of_run   (last_of_run)
    );

endmodule

// ===== rtl/tdl_front.sv =====
// tdl_front: input register stage, classifies each source byte into a column.
// Depends on tdl_pkg.
module tdl_front
    import tdl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] character,
    input  logic       end_of_input,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // hold while the stage is full and the queue cannot take it
    assign src_stall  = valid_reg && !item_ready;
    assign valid_next = src_stall ? valid_reg : src_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!src_stall && src_valid)
        begin
            item_reg.col <= classify(character, end_of_input);
            item_reg.ch  <= character;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/tdl_queue.sv =====
// tdl_queue: short FIFO of classified bytes between front and lexer engine.
// Depends on tdl_pkg.
module tdl_queue
    import tdl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  push_ready,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop
);

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/tdl_back.sv =====
// tdl_back: lexer engine, depends on tdl_pkg; runs the scan state machine on
// one byte per cycle unless stalled; restarts from start in the same cycle.
module tdl_back
    import tdl_pkg::*;
#(
    parameter int LEXEME_LIMIT  = 100,
    parameter int KEYWORD_CHARS = 9,
    parameter int LINE_BITS     = 16,
    parameter int LEN_W         = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_pop,
    output logic                 tok_valid,
    input  logic                 tok_stall,
    output logic [5:0]           token_class,
    output logic [LEN_W-1:0]     lexeme_length,
    output logic [LINE_BITS-1:0] line_number,
    output logic                 last_of_run
);

    localparam int KW_IDX_W = $clog2(KEYWORD_CHARS);

    typedef struct packed {
        class_t               cls;
        logic [LEN_W-1:0]     len;
        logic [LINE_BITS-1:0] line;
        logic                 last;
    } result_t;

    scan_state_t          state_reg;
    scan_state_t          state_next;
    logic [LEN_W-1:0]     count_reg;
    logic [LEN_W-1:0]     count_next;
    logic [LINE_BITS-1:0] line_reg;
    logic [LINE_BITS-1:0] line_next;
    logic [7:0]           window_reg [KEYWORD_CHARS];

    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_reg;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    result_t              pend_reg;

    logic                 win_wr;
    logic [KW_IDX_W-1:0]  win_idx;
    logic [LEN_W-1:0]     len_inc;
    logic                 e0_valid;
    class_t               e0_cls;
    logic [LEN_W-1:0]     e0_len;
    logic                 e1_valid;
    class_t               e1_cls;
    logic [LEN_W-1:0]     e1_len;
    logic                 restart;
    logic                 out_free;
    logic                 load_out;
    logic                 move_pend;
    class_t               kw_cls;
    logic                 kw_hit;
    result_t              res0;
    result_t              res1;

    // keyword lookup over the window, all keywords compared in parallel
    always_comb
    begin
        kw_hit = 1'b0;
        kw_cls = CLS_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            logic same;
            same = (count_reg == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX; i++)
            begin
                int pos;
                pos = (i < KW_LEN[k]) ? (KW_LEN[k] - 1 - i) : 0;
                if (i < KW_LEN[k] && window_reg[i] != KW_TEXT[k][pos * 8 +: 8])
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                kw_hit = 1'b1;
                kw_cls = CLS_KEYWORD0 + class_t'(k);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        line_next  = line_reg;
        win_wr     = 1'b0;
        win_idx    = count_reg[KW_IDX_W-1:0];
        e0_valid   = 1'b0;
        e0_cls     = CLS_IDENT;
        e0_len     = count_reg;
        e1_valid   = 1'b0;
        e1_cls     = CLS_END;
        e1_len     = '0;
        restart    = 1'b0;
        len_inc    = (count_reg < LEN_W'(LEXEME_LIMIT)) ? count_reg + LEN_W'(1) : count_reg;

        // first step: the gathering states
        case (state_reg)
            ST_NUMBER:
            begin
                if (item.col == COL_DIGIT)
                begin
                    win_wr     = (int'(count_reg) < KEYWORD_CHARS);
                    count_next = len_inc;
                end
                else if (item.col == COL_LETTER)
                begin
                    e0_valid   = 1'b1;
                    e0_cls     = CLS_BAD_NUMBER;
                    e0_len     = len_inc;
                    state_next = ST_START;
                    count_next = '0;
                end
                else
                begin
                    e0_valid = 1'b1;
                    e0_cls   = CLS_INTEGER;
                    restart  = 1'b1;
                end
            end
            ST_IDENT:
            begin
                if (item.col == COL_LETTER || item.col == COL_DIGIT)
                begin
                    win_wr     = (int'(count_reg) < KEYWORD_CHARS);
                    count_next = len_inc;
                end
                else
                begin
                    e0_valid = 1'b1;
                    e0_cls   = kw_hit ? kw_cls : CLS_IDENT;
                    restart  = 1'b1;
                end
            end
            ST_COLON:
            begin
                e0_valid = 1'b1;
                if (item.col == COL_EQUAL)
                begin
                    e0_cls     = CLS_BECOMES;
                    e0_len     = len_inc;
                    state_next = ST_START;
                    count_next = '0;
                end
                else
                begin
                    e0_cls  = CLS_BAD_ASSIGN;
                    restart = 1'b1;
                end
            end
            ST_LESS:
            begin
                e0_valid = 1'b1;
                if (item.col == COL_EQUAL || item.col == COL_GREATER)
                begin
                    e0_cls     = (item.col == COL_EQUAL) ? CLS_LESS_EQ : CLS_NOT_EQUAL;
                    e0_len     = len_inc;
                    state_next = ST_START;
                    count_next = '0;
                end
                else
                begin
                    e0_cls  = CLS_LESS;
                    restart = 1'b1;
                end
            end
            ST_GREATER:
            begin
                e0_valid = 1'b1;
                if (item.col == COL_EQUAL)
                begin
                    e0_cls     = CLS_GREATER_EQ;
                    e0_len     = len_inc;
                    state_next = ST_START;
                    count_next = '0;
                end
                else
                begin
                    e0_cls  = CLS_GREATER;
                    restart = 1'b1;
                end
            end
            ST_COMMENT:
            begin
                if (item.col == COL_RBRACE)
                begin
                    state_next = ST_START;
                    count_next = '0;
                end
                else if (item.col == COL_LF || item.col == COL_END)
                begin
                    e0_valid = 1'b1;
                    e0_cls   = CLS_BAD_COMMENT;
                    restart  = 1'b1;
                end
                else
                begin
                    win_wr     = (int'(count_reg) < KEYWORD_CHARS);
                    count_next = len_inc;
                end
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase

        // second step: from the start state, same byte
        if (restart)
        begin
            state_next = ST_START;
            count_next = '0;
            e1_len     = LEN_W'(1);
            case (item.col)
                COL_LETTER:  state_next = ST_IDENT;
                COL_DIGIT:   state_next = ST_NUMBER;
                COL_COLON:   state_next = ST_COLON;
                COL_LESS:    state_next = ST_LESS;
                COL_GREATER: state_next = ST_GREATER;
                COL_LBRACE:  state_next = ST_COMMENT;
                COL_LF:
                begin
                    if (line_reg != '1)
                    begin
                        line_next = line_reg + LINE_BITS'(1);
                    end
                end
                COL_END:
                begin
                    e1_valid = 1'b1;
                    e1_cls   = CLS_END;
                    e1_len   = '0;
                end
                COL_EQUAL:   begin e1_valid = 1'b1; e1_cls = CLS_EQUAL;       end
                COL_PLUS:    begin e1_valid = 1'b1; e1_cls = CLS_PLUS;        end
                COL_MINUS:   begin e1_valid = 1'b1; e1_cls = CLS_MINUS;       end
                COL_SEMI:    begin e1_valid = 1'b1; e1_cls = CLS_SEMI;        end
                COL_COMMA:   begin e1_valid = 1'b1; e1_cls = CLS_COMMA;       end
                COL_LPAREN:  begin e1_valid = 1'b1; e1_cls = CLS_LPAREN;      end
                COL_RPAREN:  begin e1_valid = 1'b1; e1_cls = CLS_RPAREN;      end
                COL_RBRACE:  begin e1_valid = 1'b1; e1_cls = CLS_BAD_COMMENT; end
                COL_PERIOD:  begin e1_valid = 1'b1; e1_cls = CLS_PERIOD;      end
                COL_STAR:    begin e1_valid = 1'b1; e1_cls = CLS_STAR;        end
                COL_SLASH:   begin e1_valid = 1'b1; e1_cls = CLS_SLASH;       end
                COL_FOREIGN: begin e1_valid = 1'b1; e1_cls = CLS_FOREIGN;     end
                default:     ;
            endcase
            if (state_next != ST_START)
            begin
                // lexeme opens with this byte
                count_next = LEN_W'(1);
                win_wr     = 1'b1;
                win_idx    = '0;
            end
        end
    end

    // result ordering: gather result first, start-state result second
    always_comb
    begin
        res0.cls  = e0_valid ? e0_cls : e1_cls;
        res0.len  = e0_valid ? e0_len : e1_len;
        res0.line = line_reg;
        res0.last = !(e0_valid && e1_valid);
        res1.cls  = e1_cls;
        res1.len  = e1_len;
        res1.line = line_reg;
        res1.last = 1'b1;
    end

    assign out_free  = !out_valid_reg || !tok_stall;
    assign move_pend = pend_valid_reg && out_free;
    // an item that makes no token never waits on the output side
    assign item_pop  = item_valid &&
                       (!(e0_valid || e1_valid) || (!pend_valid_reg && out_free));
    assign load_out  = item_pop && (e0_valid || e1_valid);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        if (move_pend)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (load_out)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = e0_valid && e1_valid;
        end
        else if (out_valid_reg && !tok_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_START;
            count_reg      <= '0;
            line_reg       <= LINE_BITS'(1);
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
                line_reg  <= line_next;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop && win_wr)
        begin
            window_reg[win_idx] <= item.ch;
        end
        if (move_pend)
        begin
            out_reg <= pend_reg;
        end
        else if (load_out)
        begin
            out_reg <= res0;
        end
        if (load_out && e0_valid && e1_valid)
        begin
            pend_reg <= res1;
        end
    end

    assign tok_valid     = out_valid_reg;
    assign token_class   = out_reg.cls;
    assign lexeme_length = out_reg.len;
    assign line_number   = out_reg.line;
    assign last_of_run   = out_reg.last;

endmodule

// ===== sim/table_driven_lexer_tb.sv =====
// table_driven_lexer_tb: self-checking bench for the table-driven lexer.
// Holds its own token predictor in a small scoreboard class.
// Depends on rtl/tdl_pkg.sv and rtl/table_driven_lexer.sv.
`timescale 1ns / 100ps

module table_driven_lexer_tb;
    import tdl_pkg::*;

    localparam int LEXEME_LIMIT  = 100;
    localparam int KEYWORD_CHARS = 9;
    localparam int LINE_BITS     = 16;
    localparam int LEN_W         = $clog2(LEXEME_LIMIT + 1);
    localparam int unsigned LINE_TOP = (1 << LINE_BITS) - 1;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_ITEMS     = 150;
    localparam int SINK_HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT   = 4000;  // cycles with no transfer at all
    localparam int REPORT_LIMIT     = 10;

    // the 19 listed symbols, in column order starting at COL_COLON
    localparam logic [7:0] SYMBOL_BYTES [19] = '{
        8'h3A, 8'h3D, 8'h2B, 8'h2D, 8'h3C, 8'h3E, 8'h3B, 8'h2C, 8'h28, 8'h29,
        8'h7B, 8'h7D, 8'h27, 8'h09, 8'h0A, 8'h20, 8'h2E, 8'h2A, 8'h2F
    };

    // one expected or observed token
    typedef struct packed {
        class_t               cls;
        logic [LEN_W-1:0]     len;
        logic [LINE_BITS-1:0] line;
        logic                 last;
    } token_t;

    // what a gathering state does with its lookahead byte
    typedef enum {KEEP_GOING, LOOKAHEAD_TAKEN, LOOKAHEAD_AGAIN} gather_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 src_valid;
    logic                 src_stall;
    logic [7:0]           character;
    logic                 end_of_input;
    logic                 tok_valid;
    logic                 tok_stall;
    logic [5:0]           token_class;
    logic [LEN_W-1:0]     lexeme_length;
    logic [LINE_BITS-1:0] line_number;
    logic                 last_of_run;

    bit no_idle;        // both sides run without gaps while set
    bit sink_hold_req;  // asks the token sink for one long hold-off
    int sent_items;
    int idle_cycles;

    string op_texts [17] = '{
        ":=", "<>", "<=", ">=", ":", "<", ">", "+", "-", "=",
        ";", ",", "(", ")", ".", "*", "/"
    };

    // i-th byte of keyword k; package strings are right-justified
    function automatic logic [7:0] kw_char(input int k, input int i);
        logic [8*KW_MAX-1:0] word;
        word = KW_TEXT[k];
        return word[(KW_LEN[k] - 1 - i) * 8 +: 8];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Token predictor and scoreboard
    // ------------------------------------------------------------------
    class lexer_scoreboard;
        scan_state_t state;
        int unsigned lex_count;
        logic [7:0]  kw_window [KEYWORD_CHARS];
        int unsigned line_count;
        token_t      expected_tokens [$];
        token_t      run [$];
        int unsigned failures;

        function new();
            state      = ST_START;
            lex_count  = 0;
            line_count = 1;
            failures   = 0;
            foreach (kw_window[i])
                kw_window[i] = 8'h00;
        endfunction

        function col_t char_column(input logic [7:0] ch, input logic eoi);
            if (eoi)
                return COL_END;
            if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A))
                return COL_LETTER;
            if (ch >= 8'h30 && ch <= 8'h39)
                return COL_DIGIT;
            for (int i = 0; i < 19; i++)
                if (SYMBOL_BYTES[i] == ch)
                    return col_t'(i + 2);
            return COL_FOREIGN;
        endfunction

        function void emit(input class_t cls, input int unsigned len);
            token_t t;
            t.cls  = cls;
            t.len  = len[LEN_W-1:0];
            t.line = line_count[LINE_BITS-1:0];
            t.last = 1'b0;
            run.push_back(t);
        endfunction

        function void append(input logic [7:0] ch);
            if (lex_count < KEYWORD_CHARS)
                kw_window[lex_count] = ch;
            if (lex_count < LEXEME_LIMIT)
                lex_count++;
        endfunction

        // length once the consumed lookahead joins the lexeme
        function int unsigned grown_len();
            return (lex_count < LEXEME_LIMIT) ? lex_count + 1 : lex_count;
        endfunction

        function class_t word_class();
            bit hit;
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (lex_count == KW_LEN[k])
                begin
                    hit = 1'b1;
                    for (int i = 0; i < KW_LEN[k]; i++)
                        if (kw_window[i] != kw_char(k, i))
                            hit = 1'b0;
                    if (hit)
                        return class_t'(CLS_KEYWORD0 + k);
                end
            end
            return CLS_IDENT;
        endfunction

        function void start_step(input col_t col, input logic [7:0] ch);
            state     = ST_START;
            lex_count = 0;
            case (col)
                COL_LETTER:  begin state = ST_IDENT;   append(ch); end
                COL_DIGIT:   begin state = ST_NUMBER;  append(ch); end
                COL_COLON:   begin state = ST_COLON;   append(ch); end
                COL_LESS:    begin state = ST_LESS;    append(ch); end
                COL_GREATER: begin state = ST_GREATER; append(ch); end
                COL_LBRACE:  begin state = ST_COMMENT; append(ch); end
                COL_LF:
                begin
                    if (line_count < LINE_TOP)
                        line_count++;
                end
                COL_END:     emit(CLS_END, 0);
                COL_EQUAL:   emit(CLS_EQUAL, 1);
                COL_PLUS:    emit(CLS_PLUS, 1);
                COL_MINUS:   emit(CLS_MINUS, 1);
                COL_SEMI:    emit(CLS_SEMI, 1);
                COL_COMMA:   emit(CLS_COMMA, 1);
                COL_LPAREN:  emit(CLS_LPAREN, 1);
                COL_RPAREN:  emit(CLS_RPAREN, 1);
                COL_RBRACE:  emit(CLS_BAD_COMMENT, 1);  // stray closer
                COL_PERIOD:  emit(CLS_PERIOD, 1);
                COL_STAR:    emit(CLS_STAR, 1);
                COL_SLASH:   emit(CLS_SLASH, 1);
                COL_FOREIGN: emit(CLS_FOREIGN, 1);
                default:     ;  // quote, tab, space: skipped
            endcase
        endfunction

        function gather_result_t gather_step(input col_t col, input logic [7:0] ch);
            case (state)
                ST_NUMBER:
                begin
                    if (col == COL_DIGIT)
                    begin
                        append(ch);
                        return KEEP_GOING;
                    end
                    if (col == COL_LETTER)
                    begin
                        emit(CLS_BAD_NUMBER, grown_len());
                        return LOOKAHEAD_TAKEN;
                    end
                    emit(CLS_INTEGER, lex_count);
                    return LOOKAHEAD_AGAIN;
                end
                ST_IDENT:
                begin
                    if (col == COL_LETTER || col == COL_DIGIT)
                    begin
                        append(ch);
                        return KEEP_GOING;
                    end
                    emit(word_class(), lex_count);
                    return LOOKAHEAD_AGAIN;
                end
                ST_COLON:
                begin
                    if (col == COL_EQUAL)
                    begin
                        emit(CLS_BECOMES, grown_len());
                        return LOOKAHEAD_TAKEN;
                    end
                    emit(CLS_BAD_ASSIGN, lex_count);
                    return LOOKAHEAD_AGAIN;
                end
                ST_LESS:
                begin
                    if (col == COL_EQUAL)
                    begin
                        emit(CLS_LESS_EQ, grown_len());
                        return LOOKAHEAD_TAKEN;
                    end
                    if (col == COL_GREATER)
                    begin
                        emit(CLS_NOT_EQUAL, grown_len());
                        return LOOKAHEAD_TAKEN;
                    end
                    emit(CLS_LESS, lex_count);
                    return LOOKAHEAD_AGAIN;
                end
                ST_GREATER:
                begin
                    if (col == COL_EQUAL)
                    begin
                        emit(CLS_GREATER_EQ, grown_len());
                        return LOOKAHEAD_TAKEN;
                    end
                    emit(CLS_GREATER, lex_count);
                    return LOOKAHEAD_AGAIN;
                end
                default:  // inside a comment
                begin
                    if (col == COL_RBRACE)
                        return LOOKAHEAD_TAKEN;
                    if (col == COL_LF || col == COL_END)
                    begin
                        emit(CLS_BAD_COMMENT, lex_count);
                        return LOOKAHEAD_AGAIN;
                    end
                    append(ch);
                    return KEEP_GOING;
                end
            endcase
        endfunction

        // a source byte was transferred: queue the tokens it causes
        function void note_source(input logic [7:0] ch, input logic eoi);
            col_t           col;
            gather_result_t act;
            run.delete();
            col = char_column(ch, eoi);
            if (state == ST_START)
                start_step(col, ch);
            else
            begin
                act = gather_step(col, ch);
                if (act == LOOKAHEAD_TAKEN)
                begin
                    state     = ST_START;
                    lex_count = 0;
                end
                else if (act == LOOKAHEAD_AGAIN)
                    start_step(col, ch);
            end
            if (run.size() > 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                expected_tokens.push_back(run[i]);
        endfunction

        // a token was transferred: compare with the oldest expectation
        function void check_token(input token_t got);
            token_t want;
            if (expected_tokens.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: unexpected token class %0d len %0d line %0d last %0b",
                             $realtime, got.cls, got.len, got.line, got.last);
                return;
            end
            want = expected_tokens.pop_front();
            if (want.cls !== got.cls || want.len !== got.len ||
                want.line !== got.line || want.last !== got.last)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("%0t: token mismatch: expected class %0d len %0d line %0d last %0b",
                             $realtime, want.cls, want.len, want.line, want.last);
                    $display("%0t:                 got class %0d len %0d line %0d last %0b",
                             $realtime, got.cls, got.len, got.line, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    lexer_scoreboard scb;

    // ------------------------------------------------------------------
    // Clock and block under test
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    table_driven_lexer #(
        .LEXEME_LIMIT  (LEXEME_LIMIT),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LINE_BITS     (LINE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .character     (character),
        .end_of_input  (end_of_input),
        .tok_valid     (tok_valid),
        .tok_stall     (tok_stall),
        .token_class   (token_class),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_of_run   (last_of_run)
    );

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the edge, source side first so a
    // byte is always predicted before any token it causes can arrive.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        token_t got;
        if (rst_n)
        begin
            if (src_valid === 1'b1 && src_stall === 1'b0)
                scb.note_source(character, end_of_input);
            if (tok_valid === 1'b1 && tok_stall === 1'b0)
            begin
                got.cls  = token_class;
                got.len  = lexeme_length;
                got.line = line_number;
                got.last = last_of_run;
                scb.check_token(got);
            end
        end
    end

    // Watchdog: run is stuck if no transfer happens on either side for long
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid === 1'b1 && src_stall === 1'b0) ||
            (tok_valid === 1'b1 && tok_stall === 1'b0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Token sink: random stall runs, plus one long hold-off on request so
    // the lexer backs up and stalls its source side.
    // ------------------------------------------------------------------
    initial
    begin : token_sink
        int stall_len;
        tok_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                stall_len = SINK_HOLD_CYCLES;
            end
            else
                stall_len = pick_gap();
            if (stall_len > 0)
            begin
                tok_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            tok_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Source driver tasks
    // ------------------------------------------------------------------

    // offer one byte after a random gap; returns at the transfer edge
    task automatic send_byte(input logic [7:0] ch, input logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid    <= 1'b1;
        character    <= ch;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (src_stall !== 1'b0);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // stop offering and wait for every predicted token, then let it settle
    task automatic wait_drained();
        src_valid <= 1'b0;
        while (scb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    // one well-formed-ish lexeme with random content, or noise
    task automatic send_random_token();
        int          pick;
        int          n;
        int          k;
        logic [7:0]  ch;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            // keyword, sometimes spoiled by case or an extra character
            k = $urandom_range(0, KW_COUNT - 1);
            for (int i = 0; i < KW_LEN[k]; i++)
            begin
                ch = kw_char(k, i);
                if ($urandom_range(0, 11) == 0)
                    ch = ch | 8'h20;
                send_byte(ch, 1'b0);
            end
            if ($urandom_range(0, 7) == 0)
                send_byte(($urandom_range(0, 1) != 0) ? random_letter() : random_digit(),
                          1'b0);
        end
        else if (pick < 36)
        begin
            // identifier, rarely longer than the lexeme limit
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(95, 110) : $urandom_range(1, 10);
            send_byte(random_letter(), 1'b0);
            for (int i = 1; i < n; i++)
                send_byte(($urandom_range(0, 3) == 0) ? random_digit() : random_letter(), 1'b0);
        end
        else if (pick < 50)
        begin
            // number, sometimes spoiled by a trailing letter
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(98, 104) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte(random_digit(), 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_byte(random_letter(), 1'b0);
        end
        else if (pick < 68)
            send_text(op_texts[$urandom_range(0, 16)]);
        else if (pick < 76)
        begin
            // comment; some end at a newline or end of input instead
            send_byte(8'h7B, 1'b0);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
            begin
                do
                    ch = 8'($urandom_range(0, 255));
                while (ch == 8'h7D || ch == 8'h0A);
                send_byte(ch, 1'b0);
            end
            k = $urandom_range(0, 19);
            if (k == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            else if (k < 5)
                send_byte(8'h0A, 1'b0);
            else
                send_byte(8'h7D, 1'b0);
        end
        else if (pick < 84)
        begin
            k = $urandom_range(0, 3);
            send_byte((k == 0) ? 8'h20 : (k == 1) ? 8'h09 : (k == 2) ? 8'h0A : 8'h27, 1'b0);
        end
        else if (pick < 96)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        else
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        // tokens often abut, so the lookahead gets reprocessed
        if ($urandom_range(0, 1) == 0)
            send_byte(8'h20, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int  random_start;
        bit  hold_done;
        bit  drain_done;
        scb           = new();
        rst_n         = 1'b0;
        src_valid     = 1'b0;
        character     = 8'h00;
        end_of_input  = 1'b0;
        no_idle       = 1'b0;
        sink_hold_req = 1'b0;
        sent_items    = 0;
        idle_cycles   = 0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: malformed number, every operator and its lookahead
        // cases, malformed assignment, two tokens from one byte.
        send_text("12a:=+-=<<><=>>=;,)(:x.*/");
        // stray closer, swallowed comment, foreign bytes at the extremes
        send_text("}{c}#");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // skipped characters, then a keyword ending on a symbol
        send_text("'\t PROCEDURE;");
        // comment cut by a newline, then one cut by end of input,
        // then a repeated end of input
        send_text("{d\n{e");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);

        // long lexemes: identifier, number spoiled by a letter, comment
        for (int i = 0; i < 102; i++)
            send_byte(random_letter(), 1'b0);
        send_byte(8'h20, 1'b0);
        for (int i = 0; i < 101; i++)
            send_byte(random_digit(), 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(8'h7B, 1'b0);
        for (int i = 0; i < 101; i++)
            send_byte(8'h61, 1'b0);
        send_byte(8'h0A, 1'b0);

        // Random lexeme stream with idle gaps, one long sink hold-off,
        // one full drain and one stretch with no gaps at all.
        random_start = sent_items;
        while (sent_items < random_start + RANDOM_ITEMS)
        begin
            if (!hold_done && sent_items >= random_start + 40)
            begin
                hold_done     = 1'b1;
                sink_hold_req = 1'b1;
            end
            if (!drain_done && sent_items >= random_start + 90)
            begin
                drain_done = 1'b1;
                wait_drained();
                no_idle = 1'b1;
            end
            if (no_idle && sent_items >= random_start + 120)
                no_idle = 1'b0;
            send_random_token();
        end

        no_idle = 1'b0;
        send_text("x;");
        send_byte(8'h00, 1'b1);

        wait_drained();
        if (scb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tdl_pkg.sv
rtl/tdl_front.sv
rtl/tdl_queue.sv
rtl/tdl_back.sv
rtl/table_driven_lexer.sv
sim/table_driven_lexer_tb.sv
